@@ hw/rtl/acomp_pkg.sv @@
package acomp_pkg;

  // One layer sample as it arrives at the input channel
  typedef struct packed {
    logic [7:0] layer_red;
    logic [7:0] layer_green;
    logic [7:0] layer_blue;
    logic [7:0] layer_alpha;
    logic       layer_covers;
    logic       last_layer;
  } layer_sample_t;

  // One composited pixel as it leaves the output channel
  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  // Classified operation handed from the front end to the back end
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } comp_op_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    comp_op_t op;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SPLIT,
    ST_ACCUM,
    ST_EMIT
  } back_state_e;

  localparam logic [7:0] FULL_ALPHA = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_BG_RED   = 2'd0;
  localparam logic [1:0] CFG_BG_GREEN = 2'd1;
  localparam logic [1:0] CFG_BG_BLUE  = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Exact floor(x / 255) for x up to 255*255 + 254
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

@@ hw/rtl/acomp_front.sv @@
module acomp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  acomp_pkg::layer_sample_t    in_data_i,
  input  logic                        pop_i,
  output acomp_pkg::queue_head_t      head_o
);
  import acomp_pkg::*;

  comp_op_t                 entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]   count_q, count_d;
  comp_op_t                 new_op;
  logic                     push;
  logic                     pop;

  // Classify: an uncovered sample contributes nothing, so it becomes zero alpha
  always_comb begin
    new_op.red   = in_data_i.layer_red;
    new_op.green = in_data_i.layer_green;
    new_op.blue  = in_data_i.layer_blue;
    new_op.alpha = in_data_i.layer_covers ? in_data_i.layer_alpha : 8'd0;
    new_op.last  = in_data_i.last_layer;
  end

  assign in_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.op    = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_op;
    end
  end

endmodule

@@ hw/rtl/acomp_back.sv @@
module acomp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  acomp_pkg::queue_head_t      head_i,
  output logic                        pop_o,
  input  acomp_pkg::pixel_t           bg_color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output acomp_pkg::pixel_t           out_data_o
);
  import acomp_pkg::*;

  back_state_e state_q, state_d;

  comp_op_t    op_q;
  logic        bg_pass_q;
  logic [15:0] scale_q;
  logic [7:0]  acc_alpha_q;
  logic [7:0]  acc_q      [3];
  logic [15:0] lo_prod_q  [3];
  logic [15:0] hi_prod_q  [3];
  logic        out_valid_q;
  pixel_t      out_q;

  logic [7:0]  rest;
  logic [7:0]  split_hi;
  logic [15:0] split_lo_w;
  logic [7:0]  split_lo;
  logic [7:0]  color      [3];
  logic [7:0]  acc_sum    [3];
  logic [15:0] mid        [3];

  logic        out_free;
  logic        load_next;
  logic        load_bg;
  logic        do_scale;
  logic        do_split;
  logic        do_accum;
  logic        do_emit;

  assign out_free = !out_valid_q || out_ready_i;

  // Datapath helpers
  always_comb begin
    rest       = FULL_ALPHA - acc_alpha_q;
    split_hi   = div255(scale_q);
    split_lo_w = scale_q - (({8'd0, split_hi} << 8) - {8'd0, split_hi});
    split_lo   = split_lo_w[7:0];
    color[0]   = op_q.red;
    color[1]   = op_q.green;
    color[2]   = op_q.blue;
    for (int c = 0; c < 3; c++) begin
      mid[c]     = hi_prod_q[c] + {8'd0, div255(lo_prod_q[c])};
      acc_sum[c] = acc_q[c] + div255(mid[c]);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (head_i.valid) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SPLIT;
      ST_SPLIT: state_d = ST_ACCUM;
      ST_ACCUM: begin
        if (op_q.last) begin
          state_d = bg_pass_q ? ST_EMIT : ST_SCALE;
        end else begin
          state_d = head_i.valid ? ST_SCALE : ST_IDLE;
        end
      end
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    load_next = 1'b0;
    load_bg   = 1'b0;
    do_scale  = 1'b0;
    do_split  = 1'b0;
    do_accum  = 1'b0;
    do_emit   = 1'b0;
    unique case (state_q)
      ST_IDLE:  load_next = head_i.valid;
      ST_SCALE: do_scale = 1'b1;
      ST_SPLIT: do_split = 1'b1;
      ST_ACCUM: begin
        do_accum  = 1'b1;
        load_next = !op_q.last && head_i.valid;
        load_bg   = op_q.last && !bg_pass_q;
      end
      ST_EMIT:  do_emit = out_free;
      default:  ;
    endcase
  end

  assign pop_o = load_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bg_pass_q   <= 1'b0;
      acc_alpha_q <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Background pass runs as one more opaque operation
      if (load_next) begin
        bg_pass_q <= 1'b0;
      end else if (load_bg) begin
        bg_pass_q <= 1'b1;
      end

      // Coverage gained: alpha * rest / 255
      if (do_split) begin
        acc_alpha_q <= acc_alpha_q + split_hi;
      end

      if (do_accum) begin
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= acc_sum[c];
        end
      end

      // Hand the pixel to the output register and clear the accumulator
      if (do_emit) begin
        acc_alpha_q <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= '0;
        end
      end

      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation and product registers
  always_ff @(posedge clk_i) begin
    if (load_next) begin
      op_q <= head_i.op;
    end else if (load_bg) begin
      op_q.red   <= bg_color_i.pixel_red;
      op_q.green <= bg_color_i.pixel_green;
      op_q.blue  <= bg_color_i.pixel_blue;
      op_q.alpha <= FULL_ALPHA;
      op_q.last  <= 1'b1;
    end

    // factor = alpha * rest
    if (do_scale) begin
      scale_q <= {8'd0, op_q.alpha} * {8'd0, rest};
    end

    // factor = 255 * hi + lo, color * factor / 65025 is built from both halves
    if (do_split) begin
      for (int c = 0; c < 3; c++) begin
        lo_prod_q[c] <= {8'd0, color[c]} * {8'd0, split_lo};
        hi_prod_q[c] <= {8'd0, color[c]} * {8'd0, split_hi};
      end
    end

    if (do_emit) begin
      out_q.pixel_red   <= acc_q[0];
      out_q.pixel_green <= acc_q[1];
      out_q.pixel_blue  <= acc_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/front_to_back_alpha_compositor_unit.sv @@
// Front-to-back alpha compositor for one screen pixel. Layer samples come in
// top layer first; an uncovered sample counts as zero alpha. The front end
// classifies each sample into a two-entry queue, and the back end folds it into
// the pixel accumulator step by step (scale alpha by the remaining transparency,
// split and multiply per channel, accumulate); the next sample needs the updated
// accumulated alpha, so samples are taken one at a time, the next only once the
// previous one reaches its accumulate step. An idle back end first loads a
// sample from the idle state. A last-layer sample adds a background pass through
// the same steps and a load of the output register; the back end then returns
// to idle before it loads the next sample, and the output register load waits
// while the previous pixel has not been accepted. The output register lets the
// back end take the next sample while a finished pixel waits. Background color
// registers are written through the configuration port (index 0 red, 1 green,
// 2 blue); writes to other indexes are accepted and ignored. The user must
// write them only while the block is idle; the block does not enforce this.
module front_to_back_alpha_compositor_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  acomp_pkg::layer_sample_t    in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output acomp_pkg::pixel_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import acomp_pkg::*;

  pixel_t      bg_color_q;
  queue_head_t head;
  logic        pop;

  // Background color registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_color_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BG_RED:   bg_color_q.pixel_red   <= cfg_data_i;
        CFG_BG_GREEN: bg_color_q.pixel_green <= cfg_data_i;
        CFG_BG_BLUE:  bg_color_q.pixel_blue  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  acomp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  acomp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .bg_color_i  (bg_color_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/compositor_checker.sv @@
`timescale 1ns / 1ps

// Watches the sample, pixel and configuration channels of the compositor,
// folds every accepted layer sample into its own copy of the pixel
// accumulator and checks every emitted pixel against the oldest expectation.
module compositor_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  acomp_pkg::layer_sample_t in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  acomp_pkg::pixel_t        out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  output int                       err_count_o,
  output int                       pending_o
);
  import acomp_pkg::*;

  localparam int unsigned ALPHA_MAX   = 32'(FULL_ALPHA);
  localparam int unsigned ALPHA_SQ    = ALPHA_MAX * ALPHA_MAX;
  localparam int          MAX_REPORTS = 10;

  // Background color and running pixel accumulator
  int unsigned bg_red, bg_green, bg_blue;
  int unsigned acc_red, acc_green, acc_blue, acc_alpha;
  bit          opaque_done;

  pixel_t expected_pixels[$];
  int     errors  = 0;
  int     pending = 0;

  assign err_count_o = errors;
  assign pending_o   = pending;

  task automatic flag(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic clear_pixel();
    acc_red     = 0;
    acc_green   = 0;
    acc_blue    = 0;
    acc_alpha   = 0;
    opaque_done = 1'b0;
  endtask

  // Fold one layer sample; a last-layer sample fills in the background and
  // queues the finished pixel
  task automatic fold_layer(input layer_sample_t s);
    int unsigned rest;
    int unsigned factor;
    int unsigned red, green, blue, alpha;
    pixel_t      px;
    red   = 32'(s.layer_red);
    green = 32'(s.layer_green);
    blue  = 32'(s.layer_blue);
    alpha = 32'(s.layer_alpha);
    rest  = ALPHA_MAX - acc_alpha;
    if (s.layer_covers && !opaque_done) begin
      if (alpha == ALPHA_MAX) begin
        if (acc_alpha == 0) begin
          acc_red   = red;
          acc_green = green;
          acc_blue  = blue;
        end else begin
          acc_red   = (acc_red   + red   * rest / ALPHA_MAX) % 256;
          acc_green = (acc_green + green * rest / ALPHA_MAX) % 256;
          acc_blue  = (acc_blue  + blue  * rest / ALPHA_MAX) % 256;
        end
        acc_alpha   = ALPHA_MAX;
        opaque_done = 1'b1;
      end else if (alpha != 0) begin
        factor    = alpha * rest;
        acc_red   = (acc_red   + red   * factor / ALPHA_SQ) % 256;
        acc_green = (acc_green + green * factor / ALPHA_SQ) % 256;
        acc_blue  = (acc_blue  + blue  * factor / ALPHA_SQ) % 256;
        acc_alpha = (acc_alpha + alpha * rest / ALPHA_MAX) % 256;
        if (acc_alpha >= ALPHA_MAX) opaque_done = 1'b1;
      end
    end

    if (s.last_layer) begin
      if (acc_alpha != ALPHA_MAX) begin
        rest      = ALPHA_MAX - acc_alpha;
        acc_red   = (acc_red   + bg_red   * rest / ALPHA_MAX) % 256;
        acc_green = (acc_green + bg_green * rest / ALPHA_MAX) % 256;
        acc_blue  = (acc_blue  + bg_blue  * rest / ALPHA_MAX) % 256;
      end
      px.pixel_red   = acc_red[7:0];
      px.pixel_green = acc_green[7:0];
      px.pixel_blue  = acc_blue[7:0];
      expected_pixels.push_back(px);
      clear_pixel();
    end
  endtask

  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      flag($sformatf("pixel %h emitted with none expected", got));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel_red !== want.pixel_red)
      flag($sformatf("red mismatch: expected %h got %h", want.pixel_red, got.pixel_red));
    if (got.pixel_green !== want.pixel_green)
      flag($sformatf("green mismatch: expected %h got %h",
                     want.pixel_green, got.pixel_green));
    if (got.pixel_blue !== want.pixel_blue)
      flag($sformatf("blue mismatch: expected %h got %h", want.pixel_blue, got.pixel_blue));
  endtask

  // Output side first so a stray pixel never pairs with a fresh expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_red   = 0;
      bg_green = 0;
      bg_blue  = 0;
      clear_pixel();
      expected_pixels.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_pixel(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BG_RED:   bg_red   = 32'(cfg_data_i);
          CFG_BG_GREEN: bg_green = 32'(cfg_data_i);
          CFG_BG_BLUE:  bg_blue  = 32'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) fold_layer(in_data_i);
    end
    pending = expected_pixels.size();
  end

endmodule

@@ sim/front_to_back_alpha_compositor_unit_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the alpha compositor; checking lives in
// compositor_checker.
module front_to_back_alpha_compositor_unit_test;
  import acomp_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 13;
  localparam int PHASE_ITEMS  = 400;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  layer_sample_t in_data;
  logic          out_valid;
  logic          out_ready = 1'b0;
  pixel_t        out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [7:0]    cfg_data;

  int errors;
  int pending;
  bit idle_on = 1'b1;

  front_to_back_alpha_compositor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  compositor_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .err_count_o (errors),
    .pending_o   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pixel sink backpressure
  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic layer_sample_t make_layer(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a,
                                               input bit covers, input bit last);
    layer_sample_t s;
    s.layer_red    = r;
    s.layer_green  = g;
    s.layer_blue   = b;
    s.layer_alpha  = a;
    s.layer_covers = covers;
    s.last_layer   = last;
    return s;
  endfunction

  // Mostly covering samples with a mix of opaque, clear and partial alpha
  function automatic layer_sample_t random_layer(input bit last);
    layer_sample_t s;
    int unsigned   pick;
    pick           = $urandom_range(99);
    s.layer_red    = 8'($urandom);
    s.layer_green  = 8'($urandom);
    s.layer_blue   = 8'($urandom);
    if (pick < 20) s.layer_alpha = FULL_ALPHA;
    else if (pick < 30) s.layer_alpha = 8'd0;
    else s.layer_alpha = 8'($urandom_range(254, 1));
    s.layer_covers = ($urandom_range(99) < 85);
    s.last_layer   = last;
    return s;
  endfunction

  // Called at a falling edge; leaves valid high and returns at a falling edge
  task automatic send_layer(input layer_sample_t s);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off until every pixel is out, then let trailing samples finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_background(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    write_reg(CFG_BG_RED, r);
    write_reg(CFG_BG_GREEN, g);
    write_reg(CFG_BG_BLUE, b);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Whole pixel stacks with random content, plus some loose noise samples
  task automatic random_run(input int unsigned n_items);
    int unsigned   sent;
    int unsigned   depth;
    layer_sample_t s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        s              = random_layer(1'($urandom_range(1)));
        s.layer_covers = 1'($urandom_range(1));
        send_layer(s);
        sent++;
      end else begin
        depth = $urandom_range(6, 1);
        for (int k = 0; k < depth; k++) begin
          send_layer(random_layer(k == depth - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset background: single opaque layer, then an uncovered last layer
    send_layer(make_layer(8'hFF, 8'h00, 8'h80, 8'hFF, 1'b1, 1'b1));
    send_layer(make_layer(8'hA5, 8'h5A, 8'hFF, 8'hFF, 1'b0, 1'b1));
    settle();

    program_background(8'hFF, 8'hFF, 8'hFF);
    // Uncovered last layer shows the background alone
    send_layer(make_layer(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // Zero alpha changes nothing
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0));
    send_layer(make_layer(8'h12, 8'h34, 8'h56, 8'h80, 1'b0, 1'b1));
    // Smallest and largest partial alpha, then opaque on a nonzero accumulator
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1, 1'b0));
    send_layer(make_layer(8'hFF, 8'h00, 8'hFF, 8'hFE, 1'b1, 1'b0));
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // Two half layers over the background
    send_layer(make_layer(8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1, 1'b0));
    send_layer(make_layer(8'h00, 8'hFF, 8'h00, 8'h80, 1'b1, 1'b0));
    send_layer(make_layer(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // Samples after the pixel went opaque are ignored, last one included
    send_layer(make_layer(8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, 1'b0));
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b1, 1'b0));
    send_layer(make_layer(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0));
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h40, 1'b1, 1'b1));
    // Partial then opaque, both white
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h64, 1'b1, 1'b0));
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // Nearly opaque black leaves a sliver of background
    send_layer(make_layer(8'h00, 8'h00, 8'h00, 8'hFE, 1'b1, 1'b1));
    settle();

    program_background(8'h00, 8'h00, 8'h00);
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'h7F, 1'b1, 1'b1));
    send_layer(make_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
    settle();

    // Random phases, each with its own background; one phase runs flat out
    for (int ph = 0; ph < 4; ph++) begin
      idle_on = (ph != 2);
      program_background(8'($urandom), 8'($urandom), 8'($urandom));
      random_run(PHASE_ITEMS);
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
